FILE: rtl/osdp_frame_receiver_core_assert.svh
// assertion macros for the frame receiver
`ifndef OSDP_FRAME_RECEIVER_CORE_ASSERT_SVH
`define OSDP_FRAME_RECEIVER_CORE_ASSERT_SVH

// clocked check, held off during reset
`define OSDP_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define OSDP_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/osdp_pkg.sv
`timescale 1ns / 1ps

package osdp_pkg;

   localparam int HEADER_BYTES = 5;

   localparam logic [15:0] CRC_INIT = 16'h1D0F;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic [7:0] SCB_BIT = 8'h08;

   localparam logic [7:0]  START_RESET   = 8'd83;
   localparam logic [10:0] MIN_LEN_RESET = 11'd8;
   localparam logic [10:0] MAX_LEN_RESET = 11'd1024;

   typedef enum logic [1:0] {
      REG_START_BYTE = 2'd0,
      REG_MIN_LEN    = 2'd1,
      REG_MAX_LEN    = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EVAL   = 2'd1,
      ST_SCAN   = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic       init;
      logic       step;
      logic [7:0] data;
   } crc_ctl_type;

endpackage

FILE: rtl/osdp_crc_unit.sv
`timescale 1ns / 1ps

// crc-16, one byte per cycle, msb first
module osdp_crc_unit (
   input  logic                 clock,
   input  osdp_pkg::crc_ctl_type ctl,
   output logic [15:0]          crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] acc;

   always_comb begin
      acc = crc_ff ^ {ctl.data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if ((acc & osdp_pkg::CRC_MSB) != 16'h0000) begin
            acc = {acc[14:0], 1'b0} ^ osdp_pkg::CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = osdp_pkg::CRC_INIT;
      end else if (ctl.step) begin
         crc_in = acc;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

FILE: rtl/osdp_frame_receiver_core.sv
`timescale 1ns / 1ps

// header bytes land in flops and body bytes in the buffer; a complete header is then checked in the eval state
// a completed frame then walks the buffer once, one byte a cycle, before its report is issued
// throughput: one word per cycle while a frame fills, none during the header check, crc walk and finish state
// the crc walk is bound by the single read port of the frame buffer
// reset: synchronous, active high; clears phase, counters, handshakes and registers to defaults
module osdp_frame_receiver_core #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // received bytes
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // frame reports
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_frame_length,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_control,
   output logic [7:0]  rsp_command,
   output logic        rsp_encrypted,
   output logic        rsp_bad_crc,
   output logic        rsp_truncated,
   output logic        rsp_oversize,
   output logic [31:0] rsp_frame_count,
   output logic [31:0] rsp_bad_crc_total,
   output logic [31:0] rsp_resync_total,
   output logic [31:0] rsp_oversize_total,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [16:0] DEPTH17 = 17'(BUFFER_DEPTH);
   localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
   localparam logic [FW-1:0] HDR_F = FW'(osdp_pkg::HEADER_BYTES);

   // config registers
   logic [7:0]  start_ff;
   logic [10:0] min_len_ff;
   logic [10:0] max_len_ff;
   osdp_pkg::reg_index_type csr_idx;
   logic csr_wr;

   // control
   osdp_pkg::state_type state_ff, state_in;
   osdp_pkg::phase_type phase_ff, phase_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] target_ff, target_in;
   logic          over_ff, over_in;

   // header bytes live in flops, body bytes in the buffer
   logic [7:0] hdr_ff [osdp_pkg::HEADER_BYTES];
   logic [7:0] hdr_in [osdp_pkg::HEADER_BYTES];

   // buffer
   logic [7:0]    mem [BUFFER_DEPTH];
   logic [7:0]    mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_rd_addr;

   // walk
   logic [FW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [FW-1:0] idx_d_ff, idx_d_in;
   logic [7:0]    got_lo_ff, got_lo_in;
   logic [7:0]    got_hi_ff, got_hi_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    walk_byte;
   logic [FW-1:0] n_m2;
   osdp_pkg::crc_ctl_type crc_ctl;
   logic [15:0]   crc_val;

   // counters
   logic [31:0] frames_ff, frames_in;
   logic [31:0] badcrc_ff, badcrc_in;
   logic [31:0] resync_ff, resync_in;
   logic [31:0] oversz_ff, oversz_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] o_len_ff, o_len_in;
   logic [7:0]  o_addr_ff, o_addr_in;
   logic [7:0]  o_ctrl_ff, o_ctrl_in;
   logic [7:0]  o_cmd_ff, o_cmd_in;
   logic        o_enc_ff, o_enc_in;
   logic        o_bad_ff, o_bad_in;
   logic        o_trunc_ff, o_trunc_in;
   logic        o_over_ff, o_over_in;
   // counter snapshot, held while the report waits
   logic [31:0] o_frames_ff, o_frames_in;
   logic [31:0] o_badcrc_ff, o_badcrc_in;
   logic [31:0] o_resync_ff, o_resync_in;
   logic [31:0] o_oversz_ff, o_oversz_in;

   // misc combinational
   logic          accept;
   logic [FW-1:0] fill_inc;
   logic [16:0]   limit17;
   logic [16:0]   total17;
   logic          len_short;
   logic          len_long;
   logic          found;
   logic [2:0]    shift;
   logic [2:0]    sel;
   logic          can_finish;
   logic          bad_now;

   osdp_crc_unit u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .crc   (crc_val)
   );

   // register port, byte address 4*i
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         2'd0:    csr_idx = osdp_pkg::REG_START_BYTE;
         2'd1:    csr_idx = osdp_pkg::REG_MIN_LEN;
         2'd2:    csr_idx = osdp_pkg::REG_MAX_LEN;
         default: csr_idx = osdp_pkg::REG_NONE;
      endcase
   end

   always_comb begin
      case (csr_idx)
         osdp_pkg::REG_START_BYTE: csr_prdata = {24'h0, start_ff};
         osdp_pkg::REG_MIN_LEN:    csr_prdata = {21'h0, min_len_ff};
         osdp_pkg::REG_MAX_LEN:    csr_prdata = {21'h0, max_len_ff};
         default:                  csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= osdp_pkg::START_RESET;
         min_len_ff <= osdp_pkg::MIN_LEN_RESET;
         max_len_ff <= osdp_pkg::MAX_LEN_RESET;
      end else if (csr_wr && (csr_paddr[1:0] == 2'b00)) begin
         case (csr_idx)
            osdp_pkg::REG_START_BYTE: start_ff   <= csr_pwdata[7:0];
            osdp_pkg::REG_MIN_LEN:    min_len_ff <= csr_pwdata[10:0];
            osdp_pkg::REG_MAX_LEN:    max_len_ff <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   // handshake: words only taken when idle
   assign req_ready = (state_ff == osdp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fill_inc  = fill_ff + FW'(1);

   // effective length limit is capped by the buffer
   assign limit17 = ({6'h0, max_len_ff} < DEPTH17) ? {6'h0, max_len_ff} : DEPTH17;
   assign total17 = {1'b0, hdr_ff[3], hdr_ff[2]};
   assign len_short = total17 < {6'h0, min_len_ff};
   assign len_long  = total17 > limit17;

   // first start byte held after offset zero
   always_comb begin
      found = 1'b0;
      shift = 3'd0;
      for (int i = osdp_pkg::HEADER_BYTES - 1; i >= 1; i--) begin
         if (hdr_ff[i] == start_ff) begin
            found = 1'b1;
            shift = 3'(i);
         end
      end
   end

   // walk byte: header flops below offset five, else buffer data
   assign walk_byte = (idx_d_ff < HDR_F) ? hdr_ff[idx_d_ff[2:0]] : mem_q_ff;
   assign n_m2 = fill_ff - FW'(2);
   assign mem_rd_addr = rd_idx_ff[AW-1:0];
   assign can_finish = !rsp_valid_ff || rsp_ready;
   assign bad_now = (fill_ff >= FW'(2)) && ({got_hi_ff, got_lo_ff} != crc_val);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         osdp_pkg::ST_IDLE: begin
            if (accept && (phase_ff == osdp_pkg::PH_HEADER) && (fill_inc >= HDR_F)) begin
               state_in = osdp_pkg::ST_EVAL;
            end else if (accept && (phase_ff == osdp_pkg::PH_BODY)) begin
               if (fill_ff < DEPTH_F) begin
                  if (({{(17-FW){1'b0}}, fill_inc} >= {{(17-FW){1'b0}}, target_ff}) ||
                      ({{(17-FW){1'b0}}, fill_inc} >= limit17)) begin
                     state_in = osdp_pkg::ST_SCAN;
                  end
               end else if ((fill_ff >= target_ff) ||
                            ({{(17-FW){1'b0}}, fill_ff} >= limit17)) begin
                  state_in = osdp_pkg::ST_SCAN;
               end
            end
         end
         osdp_pkg::ST_EVAL: begin
            if (!len_short && !len_long && (total17 <= 17'(osdp_pkg::HEADER_BYTES))) begin
               state_in = osdp_pkg::ST_SCAN;
            end else begin
               state_in = osdp_pkg::ST_IDLE;
            end
         end
         osdp_pkg::ST_SCAN: begin
            if ((rd_idx_ff == fill_ff) && !rd_vld_ff) begin
               state_in = osdp_pkg::ST_FINISH;
            end
         end
         osdp_pkg::ST_FINISH: begin
            if (can_finish) begin
               state_in = osdp_pkg::ST_IDLE;
            end
         end
         default: state_in = osdp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      target_in = target_ff;
      over_in   = over_ff;
      for (int j = 0; j < osdp_pkg::HEADER_BYTES; j++) begin
         hdr_in[j] = hdr_ff[j];
      end
      mem_we    = 1'b0;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = 1'b0;
      idx_d_in  = rd_idx_ff;
      got_lo_in = got_lo_ff;
      got_hi_in = got_hi_ff;
      cmd_in    = cmd_ff;
      crc_ctl   = '{init: 1'b0, step: 1'b0, data: walk_byte};
      frames_in = frames_ff;
      badcrc_in = badcrc_ff;
      resync_in = resync_ff;
      oversz_in = oversz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_len_in   = o_len_ff;
      o_addr_in  = o_addr_ff;
      o_ctrl_in  = o_ctrl_ff;
      o_cmd_in   = o_cmd_ff;
      o_enc_in   = o_enc_ff;
      o_bad_in   = o_bad_ff;
      o_trunc_in = o_trunc_ff;
      o_over_in  = o_over_ff;
      o_frames_in = o_frames_ff;
      o_badcrc_in = o_badcrc_ff;
      o_resync_in = o_resync_ff;
      o_oversz_in = o_oversz_ff;
      sel = 3'd0;

      case (state_ff)
         osdp_pkg::ST_IDLE: begin
            rd_idx_in = '0;
            cmd_in    = 8'h00;
            crc_ctl.init = 1'b1;
            if (accept) begin
               case (phase_ff)
                  osdp_pkg::PH_HEADER: begin
                     hdr_in[fill_ff[2:0]] = req_rx_byte;
                     fill_in = fill_inc;
                  end
                  osdp_pkg::PH_BODY: begin
                     if (fill_ff < DEPTH_F) begin
                        mem_we  = 1'b1;
                        fill_in = fill_inc;
                     end
                     // target reached wins over the limit
                     if (({{(17-FW){1'b0}}, fill_in} >= {{(17-FW){1'b0}}, target_ff})) begin
                        over_in = 1'b0;
                     end else begin
                        over_in = 1'b1;
                     end
                  end
                  default: begin
                     if (req_rx_byte == start_ff) begin
                        hdr_in[0] = req_rx_byte;
                        fill_in   = FW'(1);
                        target_in = '0;
                        phase_in  = osdp_pkg::PH_HEADER;
                     end else begin
                        phase_in = osdp_pkg::PH_HUNT;
                     end
                  end
               endcase
            end
         end
         osdp_pkg::ST_EVAL: begin
            crc_ctl.init = 1'b1;
            if (len_short || len_long) begin
               resync_in = resync_ff + 32'd1;
               if (!len_short) begin
                  oversz_in = oversz_ff + 32'd1;
               end
               if (found) begin
                  // slide the header down to the next start byte
                  for (int j = 0; j < osdp_pkg::HEADER_BYTES; j++) begin
                     sel = 3'(j) + shift;
                     if (sel < 3'(osdp_pkg::HEADER_BYTES)) begin
                        hdr_in[j] = hdr_ff[sel];
                     end
                  end
                  fill_in   = HDR_F - {{(FW-3){1'b0}}, shift};
                  target_in = '0;
                  phase_in  = osdp_pkg::PH_HEADER;
               end else begin
                  fill_in   = '0;
                  target_in = '0;
                  phase_in  = osdp_pkg::PH_HUNT;
               end
            end else begin
               target_in = total17[FW-1:0];
               phase_in  = osdp_pkg::PH_BODY;
               over_in   = 1'b0;
            end
         end
         osdp_pkg::ST_SCAN: begin
            if (rd_idx_ff != fill_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + FW'(1);
            end
            if (rd_vld_ff) begin
               if ((fill_ff >= FW'(2)) && (idx_d_ff < n_m2)) begin
                  crc_ctl.step = 1'b1;
               end
               if ((fill_ff >= FW'(2)) && (idx_d_ff == n_m2)) begin
                  got_lo_in = walk_byte;
               end
               if (idx_d_ff == fill_ff - FW'(1)) begin
                  got_hi_in = walk_byte;
               end
               if (idx_d_ff == HDR_F) begin
                  cmd_in = walk_byte;
               end
            end
         end
         osdp_pkg::ST_FINISH: begin
            if (can_finish) begin
               frames_in = frames_ff + 32'd1;
               if (bad_now) begin
                  badcrc_in = badcrc_ff + 32'd1;
               end
               if (over_ff) begin
                  oversz_in = oversz_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               o_len_in   = 11'(fill_ff);
               o_addr_in  = hdr_ff[1];
               o_ctrl_in  = hdr_ff[4];
               o_cmd_in   = cmd_ff;
               o_enc_in   = (hdr_ff[4] & osdp_pkg::SCB_BIT) != 8'h00;
               o_bad_in   = bad_now;
               o_trunc_in = over_ff || (fill_ff < FW'(2));
               o_over_in  = over_ff;
               o_frames_in = frames_in;
               o_badcrc_in = badcrc_in;
               o_resync_in = resync_ff;
               o_oversz_in = oversz_in;
               fill_in    = '0;
               target_in  = '0;
               phase_in   = osdp_pkg::PH_HUNT;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osdp_pkg::ST_IDLE;
         phase_ff     <= osdp_pkg::PH_HUNT;
         fill_ff      <= '0;
         target_ff    <= '0;
         over_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         frames_ff    <= 32'h0;
         badcrc_ff    <= 32'h0;
         resync_ff    <= 32'h0;
         oversz_ff    <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         target_ff    <= target_in;
         over_ff      <= over_in;
         rd_vld_ff    <= rd_vld_in;
         rd_idx_ff    <= rd_idx_in;
         frames_ff    <= frames_in;
         badcrc_ff    <= badcrc_in;
         resync_ff    <= resync_in;
         oversz_ff    <= oversz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < osdp_pkg::HEADER_BYTES; j++) begin
         hdr_ff[j] <= hdr_in[j];
      end
      idx_d_ff   <= idx_d_in;
      got_lo_ff  <= got_lo_in;
      got_hi_ff  <= got_hi_in;
      cmd_ff     <= cmd_in;
      o_len_ff   <= o_len_in;
      o_addr_ff  <= o_addr_in;
      o_ctrl_ff  <= o_ctrl_in;
      o_cmd_ff   <= o_cmd_in;
      o_enc_ff   <= o_enc_in;
      o_bad_ff   <= o_bad_in;
      o_trunc_ff <= o_trunc_in;
      o_over_ff  <= o_over_in;
      o_frames_ff <= o_frames_in;
      o_badcrc_ff <= o_badcrc_in;
      o_resync_ff <= o_resync_in;
      o_oversz_ff <= o_oversz_in;
   end

   // frame buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[AW-1:0]] <= req_rx_byte;
      end
      mem_q_ff <= mem[mem_rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_length   = o_len_ff;
   assign rsp_address        = o_addr_ff;
   assign rsp_control        = o_ctrl_ff;
   assign rsp_command        = o_cmd_ff;
   assign rsp_encrypted      = o_enc_ff;
   assign rsp_bad_crc        = o_bad_ff;
   assign rsp_truncated      = o_trunc_ff;
   assign rsp_oversize       = o_over_ff;
   assign rsp_frame_count    = o_frames_ff;
   assign rsp_bad_crc_total  = o_badcrc_ff;
   assign rsp_resync_total   = o_resync_ff;
   assign rsp_oversize_total = o_oversz_ff;

endmodule

FILE: rtl/osdp_checker.sv
`timescale 1ns / 1ps
`include "osdp_frame_receiver_core_assert.svh"

module osdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_frame_length,
   input logic [7:0]  rsp_control,
   input logic        rsp_encrypted,
   input logic        rsp_truncated,
   input logic        rsp_oversize,
   input logic        csr_pready
);

   `OSDP_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `OSDP_ASSERT_RST(a_enc_bit, clock, reset, rsp_valid |-> (rsp_encrypted == rsp_control[3]), "encrypted flag mismatch")
   `OSDP_ASSERT_RST(a_over_trunc, clock, reset, rsp_valid && rsp_oversize |-> rsp_truncated, "oversize without truncated")
   `OSDP_ASSERT_RST(a_min_len, clock, reset, rsp_valid |-> (rsp_frame_length >= 11'd5), "frame shorter than header")
   `OSDP_ASSERT_ALL(a_pready, clock, csr_pready, "register port stalled")

endmodule

bind osdp_frame_receiver_core osdp_checker u_osdp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frame_length (rsp_frame_length),
   .rsp_control      (rsp_control),
   .rsp_encrypted    (rsp_encrypted),
   .rsp_truncated    (rsp_truncated),
   .rsp_oversize     (rsp_oversize),
   .csr_pready       (csr_pready)
);

FILE: sim/tb_osdp_frame_receiver_core.sv
`timescale 1ns / 1ps

module tb_osdp_frame_receiver_core;

   localparam int DEPTH       = 1024;
   localparam int DRAIN_WAIT  = 1100;     // longest crc walk plus margin
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_WORDS = 700;

   // one frame report as the block presents it
   typedef struct {
      logic [10:0] len;
      logic [7:0]  addr;
      logic [7:0]  ctrl;
      logic [7:0]  cmd;
      logic        enc;
      logic        bad;
      logic        trunc;
      logic        over;
      logic [31:0] frames;
      logic [31:0] bads;
      logic [31:0] resyncs;
      logic [31:0] overs;
   } frame_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_frame_length;
   logic [7:0]  rsp_address, rsp_control, rsp_command;
   logic        rsp_encrypted, rsp_bad_crc, rsp_truncated, rsp_oversize;
   logic [31:0] rsp_frame_count, rsp_bad_crc_total, rsp_resync_total, rsp_oversize_total;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   osdp_frame_receiver_core dut (.*);

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // deframer prediction: own copy of buffer, phase, counters, regs
   // ---------------------------------------------------------------
   logic [7:0]  rx_buf [DEPTH];
   int unsigned rx_fill, rx_target;
   osdp_pkg::phase_type rx_phase;
   logic [31:0] cnt_frames, cnt_bads, cnt_resyncs, cnt_overs;
   logic [7:0]  cfg_start;
   logic [10:0] cfg_min, cfg_max;

   frame_report_type reports_due [$];   // frame reports still to arrive
   int errors = 0;
   int unsigned cyc = 0;

   function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         c = c[15] ? ((c << 1) ^ osdp_pkg::CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic int unsigned len_limit();
      return (cfg_max < DEPTH) ? cfg_max : DEPTH;
   endfunction

   // report the frame held in the buffer
   function automatic void report_frame(bit over);
      frame_report_type r;
      logic [15:0] crc;
      logic [15:0] got;
      crc = osdp_pkg::CRC_INIT;
      r.bad = 1'b0;
      r.trunc = over;
      if (rx_fill >= 2) begin
         for (int i = 0; i < rx_fill - 2; i++) crc = crc_next(crc, rx_buf[i]);
         got = {rx_buf[rx_fill-1], rx_buf[rx_fill-2]};
         if (got != crc) begin
            r.bad = 1'b1;
            cnt_bads++;
         end
      end else begin
         r.trunc = 1'b1;
      end
      cnt_frames++;
      r.len     = rx_fill[10:0];
      r.addr    = rx_buf[1];
      r.ctrl    = rx_buf[4];
      r.cmd     = (rx_fill > 5) ? rx_buf[5] : 8'h00;
      r.enc     = (rx_buf[4] & osdp_pkg::SCB_BIT) != 0;
      r.over    = over;
      r.frames  = cnt_frames;
      r.bads    = cnt_bads;
      r.resyncs = cnt_resyncs;
      r.overs   = cnt_overs;
      reports_due.push_back(r);
   endfunction

   function automatic void to_hunt();
      rx_fill = 0;
      rx_target = 0;
      rx_phase = osdp_pkg::PH_HUNT;
   endfunction

   // slide to the next start byte held after offset 0, else hunt
   function automatic void resync_buffer();
      cnt_resyncs++;
      for (int i = 1; i < rx_fill; i++) begin
         if (rx_buf[i] == cfg_start) begin
            for (int j = 0; j < rx_fill - i; j++) rx_buf[j] = rx_buf[j+i];
            rx_fill -= i;
            rx_target = 0;
            rx_phase = osdp_pkg::PH_HEADER;
            return;
         end
      end
      to_hunt();
   endfunction

   function automatic void predict_word(logic [7:0] b);
      int unsigned total;
      case (rx_phase)
         osdp_pkg::PH_HEADER: begin
            if (rx_fill < osdp_pkg::HEADER_BYTES) rx_buf[rx_fill++] = b;
            if (rx_fill >= osdp_pkg::HEADER_BYTES) begin
               total = {rx_buf[3], rx_buf[2]};
               if (total < cfg_min) begin
                  resync_buffer();
               end else if (total > len_limit()) begin
                  cnt_overs++;
                  resync_buffer();
               end else begin
                  rx_target = total;
                  rx_phase = osdp_pkg::PH_BODY;
                  if (rx_fill >= rx_target) begin
                     report_frame(1'b0);
                     to_hunt();
                  end
               end
            end
         end
         osdp_pkg::PH_BODY: begin
            if (rx_fill < DEPTH) rx_buf[rx_fill++] = b;
            if (rx_fill >= rx_target) begin
               report_frame(1'b0);
               to_hunt();
            end else if (rx_fill >= len_limit()) begin
               cnt_overs++;
               report_frame(1'b1);
               to_hunt();
            end
         end
         default: begin
            if (b == cfg_start) begin
               rx_buf[0] = b;
               rx_fill = 1;
               rx_target = 0;
               rx_phase = osdp_pkg::PH_HEADER;
            end else begin
               rx_phase = osdp_pkg::PH_HUNT;
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // report checker
   // ---------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      frame_report_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            errors++;
            $display("%0t unexpected report: expected none, actual length %0d",
                     $time, rsp_frame_length);
         end else begin
            e = reports_due.pop_front();
            check_field("frame_length",   32'(e.len),   32'(rsp_frame_length));
            check_field("address",        32'(e.addr),  32'(rsp_address));
            check_field("control",        32'(e.ctrl),  32'(rsp_control));
            check_field("command",        32'(e.cmd),   32'(rsp_command));
            check_field("encrypted",      32'(e.enc),   32'(rsp_encrypted));
            check_field("bad_crc",        32'(e.bad),   32'(rsp_bad_crc));
            check_field("truncated",      32'(e.trunc), 32'(rsp_truncated));
            check_field("oversize",       32'(e.over),  32'(rsp_oversize));
            check_field("frame_count",    e.frames,  rsp_frame_count);
            check_field("bad_crc_total",  e.bads,    rsp_bad_crc_total);
            check_field("resync_total",   e.resyncs, rsp_resync_total);
            check_field("oversize_total", e.overs,   rsp_oversize_total);
         end
      end
   end

   // cycle counter and run limit
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYCLE_LIMIT) begin
         $display("[osdp_frame_receiver_core] ERROR");
         $finish;
      end
   end

   // receiver stall pattern, re-rolled by the tests; one slot always ready
   logic [15:0] stall_pat = 16'h0000;
   always @(negedge clock)
      rsp_ready <= ~stall_pat[cyc % 16];

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------
   int  burst_left = 0;
   bit  no_gaps = 0;
   logic [7:0] frame_q [$];

   // send one word; valid stays high for a following word
   task automatic put_word(logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = no_gaps ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      predict_word(b);
      burst_left--;
      @(negedge clock);
   endtask

   // stop sending and let every report and crc walk finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(osdp_pkg::reg_index_type idx, logic [31:0] v);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         osdp_pkg::REG_START_BYTE: cfg_start = v[7:0];
         osdp_pkg::REG_MIN_LEN:    cfg_min   = v[10:0];
         osdp_pkg::REG_MAX_LEN:    cfg_max   = v[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // build a well-formed frame, optionally with a spoiled crc
   task automatic build_frame(logic [7:0] addr, logic [7:0] ctrl, int data_len, bit spoil);
      logic [15:0] crc;
      logic [15:0] total;
      total = 16'(osdp_pkg::HEADER_BYTES + 1 + data_len + 2);
      frame_q = {cfg_start, addr, total[7:0], total[15:8], ctrl, 8'($urandom)};
      repeat (data_len) frame_q.push_back(8'($urandom));
      crc = osdp_pkg::CRC_INIT;
      foreach (frame_q[i]) crc = crc_next(crc, frame_q[i]);
      if (spoil) crc ^= 16'($urandom_range(1, 16'hFFFF));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
   endtask

   task automatic send_queue();
      foreach (frame_q[i]) put_word(frame_q[i]);
   endtask

   task automatic send_frame(logic [7:0] addr, logic [7:0] ctrl, int data_len, bit spoil);
      build_frame(addr, ctrl, data_len, spoil);
      send_queue();
   endtask

   // header only, with a chosen total length
   task automatic send_header(logic [7:0] addr, logic [15:0] total, logic [7:0] ctrl);
      frame_q = {cfg_start, addr, total[7:0], total[15:8], ctrl};
      send_queue();
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // smallest frame, reply bit, scb bit, bad crc, field extremes
   task automatic test_basic_frames();
      send_frame(8'h00, 8'h00, 0, 0);
      send_frame(8'hFF, osdp_pkg::SCB_BIT, 0, 0);
      send_frame(8'h80, 8'hF7, 3, 1);
      send_frame(8'h7F, 8'hFF, 1, 0);
   endtask

   // too short, too long, and a start byte inside a rejected header
   task automatic test_length_limits();
      send_header(8'h01, 16'd3, 8'h00);
      send_header(8'h02, 16'hFFFF, 8'h00);
      send_header(cfg_start, 16'd0, 8'h00);
      put_word(8'h00);
      send_frame(8'h05, 8'h08, 2, 0);
   endtask

   // min lowered to zero: totals at or below the header size report at once
   task automatic test_short_total();
      csr_write(osdp_pkg::REG_MIN_LEN, 32'd0);
      send_header(8'h11, 16'd5, 8'h0C);
      send_header(8'h12, 16'd0, 8'h00);
      send_header(8'h93, 16'd2, 8'h08);
      csr_write(osdp_pkg::REG_MIN_LEN, 32'd8);
   endtask

   // max lowered while a frame is partly received
   task automatic test_mid_frame_limit();
      build_frame(8'h21, 8'h04, 40, 0);
      for (int i = 0; i < 15; i++) put_word(frame_q[i]);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd20);
      for (int i = 15; i < frame_q.size(); i++) put_word(frame_q[i]);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd1024);
   endtask

   // register extremes: start codes, an unmapped register, max above buffer, min above max
   task automatic test_config_extremes();
      csr_write(osdp_pkg::REG_START_BYTE, 32'd0);
      send_frame(8'h31, 8'h00, 0, 0);
      csr_write(osdp_pkg::REG_START_BYTE, 32'hFFFF_FFFF);
      send_frame(8'h32, 8'h08, 1, 0);
      csr_write(osdp_pkg::REG_NONE, 32'h1234_5678);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd2047);
      send_frame(8'h33, 8'h00, 4, 0);
      csr_write(osdp_pkg::REG_MIN_LEN, 32'd100);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd50);
      send_header(8'h34, 16'd60, 8'h00);
      send_header(8'h35, 16'd200, 8'h00);
      csr_write(osdp_pkg::REG_MIN_LEN, 32'd8);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd8);
      send_frame(8'h36, 8'h00, 0, 0);
      send_frame(8'h37, 8'h00, 1, 0);
      csr_write(osdp_pkg::REG_MAX_LEN, 32'd1024);
      csr_write(osdp_pkg::REG_START_BYTE, 32'(osdp_pkg::START_RESET));
   endtask

   // one frame filling the whole buffer, under a full-speed receiver
   task automatic test_full_buffer();
      stall_pat = 16'h0000;
      no_gaps = 1;
      send_frame(8'h40, 8'h08, DEPTH - 8, 0);
      no_gaps = 0;
      stall_pat = 16'($urandom) & 16'h7FFF;
   endtask

   task automatic test_random();
      int sent;
      int kind;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            build_frame(8'($urandom), 8'($urandom), $urandom_range(0, 30), 0);
         end else if (kind < 85) begin
            build_frame(8'($urandom), 8'($urandom), $urandom_range(0, 30), 1);
         end else if (kind < 92) begin
            frame_q = {};
            repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
         end else begin
            // broken header: random length
            frame_q = {cfg_start, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)),
                       8'($urandom)};
         end
         send_queue();
         sent += frame_q.size();
         if ($urandom_range(0, 30) == 0) begin
            stall_pat = ($urandom_range(0, 2) == 0) ? 16'h0000 : (16'($urandom) & 16'h7FFF);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 60) == 0) begin
            case ($urandom_range(0, 2))
               0: csr_write(osdp_pkg::REG_START_BYTE, $urandom);
               1: csr_write(osdp_pkg::REG_MIN_LEN, $urandom_range(0, 12));
               default: csr_write(osdp_pkg::REG_MAX_LEN, $urandom_range(20, 1024));
            endcase
         end
         if ($urandom_range(0, 80) == 0) wait_idle();
      end
   endtask

   initial begin
      to_hunt();
      cnt_frames = 0;
      cnt_bads = 0;
      cnt_resyncs = 0;
      cnt_overs = 0;
      cfg_start = osdp_pkg::START_RESET;
      cfg_min = osdp_pkg::MIN_LEN_RESET;
      cfg_max = osdp_pkg::MAX_LEN_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      stall_pat = 16'($urandom) & 16'h7FFF;

      test_basic_frames();
      test_length_limits();
      test_short_total();
      test_mid_frame_limit();
      test_config_extremes();
      test_full_buffer();
      test_random();

      // drain: all reports back, then the last crc walk
      wait_idle();
      if (errors == 0) begin
         $display("[osdp_frame_receiver_core] OK");
      end else begin
         $display("[osdp_frame_receiver_core] ERROR");
      end
      $finish;
   end

endmodule
